### design/xtea_pkg.sv
// ============================================================================
// xtea_pkg: shared types, constants and helpers for the XTEA block cipher
// Word layouts, key register indexes and the running-sum helper.
// ============================================================================
`timescale 1ns / 1ps

package xtea_pkg;

    // Cipher constants
    localparam int unsigned ROUNDS      = 32;
    localparam int unsigned NUM_HALVES  = 2 * ROUNDS;
    localparam logic [31:0] XTEA_DELTA  = 32'h9e37_79b9;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned MIX_SHL     = 4;
    localparam int unsigned MIX_SHR     = 5;
    localparam int unsigned KEY_SEL_SHR = 11;

    // Key register file
    localparam int unsigned NUM_KEYS    = 4;
    localparam int unsigned KEY_IDX_W   = $clog2(NUM_KEYS);

    localparam logic [KEY_IDX_W-1:0] KEY_WORD0_IDX = KEY_IDX_W'(0);
    localparam logic [KEY_IDX_W-1:0] KEY_WORD1_IDX = KEY_IDX_W'(1);
    localparam logic [KEY_IDX_W-1:0] KEY_WORD2_IDX = KEY_IDX_W'(2);
    localparam logic [KEY_IDX_W-1:0] KEY_WORD3_IDX = KEY_IDX_W'(3);

    typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_t;

    // Input word: direction bit and the two block halves
    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] in_word0;
        logic [WORD_W-1:0] in_word1;
    } in_t;

    // Result word
    typedef struct packed {
        logic [WORD_W-1:0] out_word0;
        logic [WORD_W-1:0] out_word1;
    } out_t;

    // Payload carried down the round pipeline
    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } stage_t;

    // Running sum after n additions of the delta, wrapping at 32 bits
    function automatic logic [WORD_W-1:0] xtea_sum(input int unsigned n);
        logic [2*WORD_W-1:0] prod;
        prod = (2*WORD_W)'(n) * (2*WORD_W)'(XTEA_DELTA);
        return prod[WORD_W-1:0];
    endfunction

    // Feistel mixing function
    function automatic logic [WORD_W-1:0] xtea_mix(input logic [WORD_W-1:0] v);
        return ((v << MIX_SHL) ^ (v >> MIX_SHR)) + v;
    endfunction

endpackage

### design/xtea_half.sv
// ============================================================================
// xtea_half: one registered half-round of the XTEA pipeline
// Updates one block half per direction; sums are fixed per stage.
// ============================================================================
`timescale 1ns / 1ps

module xtea_half
    import xtea_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              first_half,
    input  logic [WORD_W-1:0] sum_enc,
    input  logic [WORD_W-1:0] sum_dec,
    input  key_t              key,
    input  logic              stage_in_valid,
    input  stage_t            stage_in,
    output logic              stage_out_valid,
    output stage_t            stage_out
);

    logic                 valid_reg;
    stage_t               data_reg;
    stage_t               data_next;
    logic                 upd_v1;
    logic [WORD_W-1:0]    sum_sel;
    logic [KEY_IDX_W-1:0] key_sel;
    logic [WORD_W-1:0]    src_word;
    logic [WORD_W-1:0]    round_term;

    // Pick the half to update, the key word and the running sum
    always_comb
    begin
        upd_v1     = first_half ? stage_in.mode : ~stage_in.mode;
        sum_sel    = stage_in.mode ? sum_dec : sum_enc;
        key_sel    = upd_v1 ? sum_sel[KEY_SEL_SHR +: KEY_IDX_W] : sum_sel[KEY_IDX_W-1:0];
        src_word   = upd_v1 ? stage_in.v0 : stage_in.v1;
        round_term = xtea_mix(src_word) ^ (sum_sel + key[key_sel]);
    end

    // Add when enciphering, subtract when deciphering
    always_comb
    begin
        data_next = stage_in;
        if (upd_v1)
        begin
            data_next.v1 = stage_in.mode ? stage_in.v1 - round_term
                                         : stage_in.v1 + round_term;
        end
        else
        begin
            data_next.v0 = stage_in.mode ? stage_in.v0 - round_term
                                         : stage_in.v0 + round_term;
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign stage_out_valid = valid_reg;
    assign stage_out       = data_reg;

endmodule

### design/xtea_skid.sv
// ============================================================================
// xtea_skid: output register with a one-word skid buffer
// Decouples the round pipeline from back-pressure on the result channel.
// ============================================================================
`timescale 1ns / 1ps

module xtea_skid
    import xtea_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  out_t push_data,
    output logic room,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    logic out_valid_reg;
    logic out_valid_next;
    out_t out_data_reg;
    out_t out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    out_t skid_data_reg;
    out_t skid_data_next;
    logic out_free;

    // Refill the output register from the skid first, else from the pipeline
    always_comb
    begin
        out_free        = ~out_valid_reg | out_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push_valid;
                out_data_next  = push_data;
            end
        end
        else if (push_valid && !skid_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign room      = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The skid only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && push_valid))
        else $error("skid filled without a stalled output");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid word not moved to the output register");

endmodule

### design/xtea_block_cipher.sv
// ============================================================================
// xtea_block_cipher: XTEA 64-bit block, 32 rounds, pipelined
// One block per cycle while the output skid buffer has room; stalls otherwise.
// Each of the 2*ROUNDS pipeline stages does one half-round (mix, key add, add or subtract).
// Async active-low reset clears all valid bits and the key registers to zero.
// ============================================================================
`timescale 1ns / 1ps

module xtea_block_cipher
    import xtea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_ready,
    input  in_t                  src_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output out_t                 res_data,
    input  logic                 wr_en,
    input  logic [KEY_IDX_W-1:0] wr_index,
    input  logic [WORD_W-1:0]    wr_data
);

    key_t                  key_reg;
    logic                  pipe_adv;
    logic                  skid_room;
    logic [NUM_HALVES:0]   pipe_valid;
    stage_t                pipe_data [NUM_HALVES+1];
    out_t                  push_data;

    // Write key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                KEY_WORD0_IDX: key_reg[KEY_WORD0_IDX] <= wr_data;
                KEY_WORD1_IDX: key_reg[KEY_WORD1_IDX] <= wr_data;
                KEY_WORD2_IDX: key_reg[KEY_WORD2_IDX] <= wr_data;
                KEY_WORD3_IDX: key_reg[KEY_WORD3_IDX] <= wr_data;
                default:       key_reg <= key_reg;
            endcase
        end
    end

    // Advance the whole pipeline while the skid has room
    assign pipe_adv  = skid_room;
    assign src_ready = pipe_adv;

    assign pipe_valid[0]   = src_valid & src_ready;
    assign pipe_data[0].mode = src_data.mode;
    assign pipe_data[0].v0   = src_data.in_word0;
    assign pipe_data[0].v1   = src_data.in_word1;

    // Unrolled half-round stages
    for (genvar h = 0; h < NUM_HALVES; h++)
    begin : g_half
        localparam int unsigned RND  = h / 2;
        localparam int unsigned HALF = h % 2;
        localparam logic [WORD_W-1:0] SUM_ENC = xtea_sum(RND + HALF);
        localparam logic [WORD_W-1:0] SUM_DEC = xtea_sum(ROUNDS - RND - HALF);

        xtea_half u_half (
            .clk             (clk),
            .rst_n           (rst_n),
            .advance         (pipe_adv),
            .first_half      (HALF == 0),
            .sum_enc         (SUM_ENC),
            .sum_dec         (SUM_DEC),
            .key             (key_reg),
            .stage_in_valid  (pipe_valid[h]),
            .stage_in        (pipe_data[h]),
            .stage_out_valid (pipe_valid[h+1]),
            .stage_out       (pipe_data[h+1])
        );
    end

    assign push_data.out_word0 = pipe_data[NUM_HALVES].v0;
    assign push_data.out_word1 = pipe_data[NUM_HALVES].v1;

    // Output register and skid
    xtea_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (pipe_valid[NUM_HALVES] & pipe_adv),
        .push_data  (push_data),
        .room       (skid_room),
        .out_valid  (res_valid),
        .out_ready  (res_ready),
        .out_data   (res_data)
    );

    // A stalled pipeline keeps every valid bit in place
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_adv |=> $stable(pipe_valid[NUM_HALVES:1]))
        else $error("pipeline valid bits moved during a stall");

    // An accepted word lands in the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> pipe_valid[1])
        else $error("accepted word missing from the first stage");

    // A waiting result word holds until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result word dropped or changed while waiting");

endmodule
